/* rtl/scfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg: shared types and constants of the serial frame parser
// Phase codes, register indexes, stream widths and the message record that
// the parser hands to the output stage.
// ----------------------------------------------------------------------------
package scfp_pkg;

    // Frame limits and field widths
    localparam int MAX_PAYLOAD   = 8;
    localparam int BYTE_W        = 8;
    localparam int ID_W          = 16;
    localparam int LEN_W         = 4;
    localparam int PAYLOAD_BYTES = 8;
    localparam int COUNT_W       = 4;
    localparam int SLOT_W        = 3;

    // Stream widths: message packs id, length, payload bytes, padded to bytes
    localparam int MSG_BITS      = ID_W + LEN_W + PAYLOAD_BYTES * BYTE_W;
    localparam int M_TDATA_W     = ((MSG_BITS + 7) / 8) * 8;
    localparam int S_TDATA_W     = BYTE_W;

    // Configuration port
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 1'b1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

    // Parse phases; the unused code acts as waiting for the start marker
    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_ID_HI = 3'd1,
        PH_ID_LO = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5,
        PH_END   = 3'd6
    } phase_t;

    // One completed frame; payload[0] sits in the lowest bits of the payload field
    typedef struct packed {
        logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] payload;
        logic [LEN_W-1:0]                     length;
        logic [ID_W-1:0]                      id;
    } msg_t;

endpackage

/* rtl/serial_to_can_frame_parser.sv */
`timescale 1ns / 1ps
// A message appears on the master side in the cycle after its end byte is taken.
// Throughput: one byte per cycle while not stalled; the single output register frees itself as it drains.
// The slave side stalls only while a message waits and the master side is stalled.
// Reset (rst_n, asynchronous, active low) returns to hunting for the start marker,
// clears the frame state and the output valid, and loads markers 0xAA and 0x55.
// ----------------------------------------------------------------------------
// serial_to_can_frame_parser: serial byte stream to frame message
// Holds the marker registers and the output register around the parser.
// ----------------------------------------------------------------------------
module serial_to_can_frame_parser #(
    parameter int MAX_PAYLOAD = scfp_pkg::MAX_PAYLOAD
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [scfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [scfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [scfp_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [7:0] rx_byte
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] message_id, [19:16] payload_length, [27:20] payload_0 ...
    // [83:76] payload_7, [87:84] zero
    output logic [scfp_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    logic [scfp_pkg::BYTE_W-1:0]    start_marker_reg;
    logic [scfp_pkg::BYTE_W-1:0]    end_marker_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [scfp_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                           accept;
    logic                           msg_valid;
    scfp_pkg::msg_t                 msg;

    // Take a byte whenever the output slot is free or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Write marker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= scfp_pkg::START_MARKER_RST;
            end_marker_reg   <= scfp_pkg::END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                scfp_pkg::REG_START_MARKER: start_marker_reg <= cfg_data;
                scfp_pkg::REG_END_MARKER:   end_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    scfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (accept),
        .rx_byte      (s_axis_tdata),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .msg_valid    (msg_valid),
        .msg          (msg)
    );

    // Load a new message or drop the valid once taken
    always_comb
    begin
        if (msg_valid)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (msg_valid)
            out_data_reg <= scfp_pkg::M_TDATA_W'(msg);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* rtl/scfp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_parser: byte-wise frame recognizer
// Walks start marker, id, length, payload, checksum and end marker one byte
// per accepted request and flags a completed, checked frame.
// ----------------------------------------------------------------------------
module scfp_parser #(
    parameter int MAX_PAYLOAD = scfp_pkg::MAX_PAYLOAD
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  logic [scfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic [scfp_pkg::BYTE_W-1:0] start_marker,
    input  logic [scfp_pkg::BYTE_W-1:0] end_marker,
    output logic                        msg_valid,
    output scfp_pkg::msg_t              msg
);

    scfp_pkg::phase_t                    phase_reg, phase_next;
    logic [scfp_pkg::ID_W-1:0]           id_reg, id_next;
    logic [scfp_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [scfp_pkg::PAYLOAD_BYTES-1:0][scfp_pkg::BYTE_W-1:0] store_reg, store_next;
    logic [scfp_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [scfp_pkg::BYTE_W-1:0]         csum_reg, csum_next;

    // Next state and frame bookkeeping
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        store_next = store_reg;
        count_next = count_reg;
        csum_next  = csum_reg;
        if (byte_valid)
        begin
            case (phase_reg)
                scfp_pkg::PH_ID_HI:
                begin
                    id_next    = {rx_byte, 8'h00};
                    csum_next  = csum_reg ^ rx_byte;
                    phase_next = scfp_pkg::PH_ID_LO;
                end
                scfp_pkg::PH_ID_LO:
                begin
                    id_next    = {id_reg[15:8], rx_byte};
                    csum_next  = csum_reg ^ rx_byte;
                    phase_next = scfp_pkg::PH_LEN;
                end
                scfp_pkg::PH_LEN:
                begin
                    csum_next = csum_reg ^ rx_byte;
                    if (rx_byte <= scfp_pkg::BYTE_W'(MAX_PAYLOAD))
                    begin
                        len_next   = rx_byte[scfp_pkg::LEN_W-1:0];
                        phase_next = (rx_byte == 8'h00) ? scfp_pkg::PH_CHECK
                                                        : scfp_pkg::PH_DATA;
                    end
                    else
                    begin
                        phase_next = scfp_pkg::PH_WAIT;
                    end
                end
                scfp_pkg::PH_DATA:
                begin
                    store_next[count_reg[scfp_pkg::SLOT_W-1:0]] = rx_byte;
                    csum_next  = csum_reg ^ rx_byte;
                    count_next = count_reg + 4'd1;
                    if (count_next >= len_reg)
                        phase_next = scfp_pkg::PH_CHECK;
                end
                scfp_pkg::PH_CHECK:
                begin
                    phase_next = (rx_byte == csum_reg) ? scfp_pkg::PH_END
                                                       : scfp_pkg::PH_WAIT;
                end
                scfp_pkg::PH_END:
                begin
                    phase_next = scfp_pkg::PH_WAIT;
                end
                default:
                begin
                    // Hunt for the start marker; clear the frame on a hit
                    phase_next = scfp_pkg::PH_WAIT;
                    if (rx_byte == start_marker)
                    begin
                        id_next    = '0;
                        len_next   = '0;
                        store_next = '0;
                        count_next = '0;
                        csum_next  = '0;
                        phase_next = scfp_pkg::PH_ID_HI;
                    end
                end
            endcase
        end
    end

    // Flag a finished frame on a matching end marker
    always_comb
    begin
        msg_valid      = 1'b0;
        msg.id         = id_reg;
        msg.length     = len_reg;
        msg.payload    = store_reg;
        case (phase_reg)
            scfp_pkg::PH_END: msg_valid = byte_valid && (rx_byte == end_marker);
            default:          msg_valid = 1'b0;
        endcase
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= scfp_pkg::PH_WAIT;
            id_reg    <= '0;
            len_reg   <= '0;
            store_reg <= '0;
            count_reg <= '0;
            csum_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            store_reg <= store_next;
            count_reg <= count_next;
            csum_reg  <= csum_next;
        end
    end

endmodule

/* rtl/scfp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_checker: port-level checks of the frame parser
// Watches handshakes and message contents over time; bound to the top level.
// ----------------------------------------------------------------------------
module scfp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [scfp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled message holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled message changed or vanished");

    // Input side stalls only behind a waiting, stalled message
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output slot");

    // A new message follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("message appeared without an accepted byte");

    // Length stays in range; an empty frame carries an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[19:16] <= 4'(scfp_pkg::MAX_PAYLOAD))
                          && (m_axis_tdata[19:16] != 4'd0 || m_axis_tdata[83:20] == '0))
        else $error("message length or unused payload wrong");

endmodule

bind serial_to_can_frame_parser scfp_checker u_scfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_serial_to_can_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_to_can_frame_parser: self-checking bench for the frame parser
// Streams framed and corrupted byte sequences into the parser under several
// marker settings. A scoreboard tracks the frame state byte by byte and
// compares every message with the one it predicts, field by field.
// ----------------------------------------------------------------------------
module tb_serial_to_can_frame_parser;

    import scfp_pkg::*;

    localparam int IDLE_PCT     = 33;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BYTES  = 150;
    localparam int PHASE_MSGS   = 10;
    localparam int TAIL_CYCLES  = 4;
    localparam int CYCLE_LIMIT  = 200000;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the frame state and holds the expected messages
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [BYTE_W-1:0]  start_mark;
        logic [BYTE_W-1:0]  end_mark;
        phase_t             phase;
        logic [ID_W-1:0]    cur_id;
        logic [LEN_W-1:0]   cur_len;
        logic [BYTE_W-1:0]  data_buf [PAYLOAD_BYTES];
        logic [COUNT_W-1:0] bytes_seen;
        logic [BYTE_W-1:0]  xor_acc;
        msg_t               expected_msgs [$];
        int                 mismatches;
        int                 produced;

        function new();
            start_mark  = START_MARKER_RST;
            end_mark    = END_MARKER_RST;
            phase       = PH_WAIT;
            mismatches  = 0;
            produced    = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            cur_id     = '0;
            cur_len    = '0;
            bytes_seen = '0;
            xor_acc    = '0;
            foreach (data_buf[i])
                data_buf[i] = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_START_MARKER)
                start_mark = val;
            else if (idx == REG_END_MARKER)
                end_mark = val;
        endfunction

        function int pending();
            return expected_msgs.size();
        endfunction

        // Advance the frame state by one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b);
            msg_t m;
            case (phase)
                PH_ID_HI:
                begin
                    cur_id  = {b, 8'h00};
                    xor_acc = xor_acc ^ b;
                    phase   = PH_ID_LO;
                end
                PH_ID_LO:
                begin
                    cur_id[7:0] = b;
                    xor_acc     = xor_acc ^ b;
                    phase       = PH_LEN;
                end
                PH_LEN:
                begin
                    xor_acc = xor_acc ^ b;
                    if (b <= MAX_PAYLOAD)
                    begin
                        cur_len = b[LEN_W-1:0];
                        phase   = (b == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                    else
                        phase = PH_WAIT;
                end
                PH_DATA:
                begin
                    data_buf[bytes_seen[SLOT_W-1:0]] = b;
                    xor_acc    = xor_acc ^ b;
                    bytes_seen = bytes_seen + 1'b1;
                    if (bytes_seen >= cur_len)
                        phase = PH_CHECK;
                end
                PH_CHECK:
                    phase = (b == xor_acc) ? PH_END : PH_WAIT;
                PH_END:
                begin
                    phase = PH_WAIT;
                    if (b == end_mark)
                    begin
                        m.id     = cur_id;
                        m.length = cur_len;
                        for (int i = 0; i < PAYLOAD_BYTES; i++)
                            m.payload[i] = data_buf[i];
                        expected_msgs.push_back(m);
                        produced++;
                    end
                end
                default:
                begin
                    phase = PH_WAIT;
                    if (b == start_mark)
                    begin
                        clear_frame();
                        phase = PH_ID_HI;
                    end
                end
            endcase
        endfunction

        // Compare one delivered message with the oldest expected one
        function void check_message(logic [M_TDATA_W-1:0] tdata);
            msg_t got;
            msg_t want;
            logic [M_TDATA_W-MSG_BITS-1:0] pad;
            got = msg_t'(tdata[MSG_BITS-1:0]);
            pad = tdata[M_TDATA_W-1:MSG_BITS];
            if (expected_msgs.size() == 0)
            begin
                $error("unexpected message: id %h length %0d", got.id, got.length);
                mismatches++;
                return;
            end
            want = expected_msgs.pop_front();
            if (got.id !== want.id)
            begin
                $error("message_id: expected %h, actual %h", want.id, got.id);
                mismatches++;
            end
            if (got.length !== want.length)
            begin
                $error("payload_length: expected %0d, actual %0d", want.length, got.length);
                mismatches++;
            end
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                if (got.payload[i] !== want.payload[i])
                begin
                    $error("payload_%0d: expected %h, actual %h", i, want.payload[i],
                           got.payload[i]);
                    mismatches++;
                end
            end
            if (pad !== '0)
            begin
                $error("tdata padding: expected 0, actual %h", pad);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_W-1:0]    m_axis_tdata;

    frame_scoreboard         sb;
    logic [BYTE_W-1:0]       cur_start;
    logic [BYTE_W-1:0]       cur_end;
    logic                    steady;
    logic                    pressure_on;
    logic                    pressure_done;
    int                      hold_left;
    int                      bytes_sent;
    int                      cycle_count;

    serial_to_can_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock: start low so the first rising edge comes after time zero
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off once pressure is requested
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (pressure_on && !pressure_done)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: sample both handshakes mid-cycle, where all signals are settled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_message(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one byte, with random idle cycles ahead of it, and hold until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        logic taken;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        bytes_sent++;
    endtask

    // Send one frame; a length above the limit stops after the length byte
    task automatic send_frame(input logic [BYTE_W-1:0] mark, input logic [ID_W-1:0] id,
                              input logic [BYTE_W-1:0] len_b, input logic [63:0] pl,
                              input logic [BYTE_W-1:0] csum_flip,
                              input logic [BYTE_W-1:0] end_b);
        logic [BYTE_W-1:0] csum;
        csum = id[15:8] ^ id[7:0] ^ len_b;
        send_byte(mark);
        send_byte(id[15:8]);
        send_byte(id[7:0]);
        send_byte(len_b);
        if (len_b <= MAX_PAYLOAD)
        begin
            for (int i = 0; i < len_b; i++)
            begin
                csum = csum ^ pl[8*i +: 8];
                send_byte(pl[8*i +: 8]);
            end
            send_byte(csum ^ csum_flip);
            send_byte(end_b);
        end
    endtask

    // Write one marker register while the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        if (idx == REG_START_MARKER)
            cur_start = val;
        else
            cur_end = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering, wait for every expected message, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed frames with random content, the rest broken or noise
    task automatic random_phase(input int target);
        int                first_byte;
        int                first_msg;
        int                kind;
        logic [ID_W-1:0]   id;
        logic [BYTE_W-1:0] len_b;
        logic [63:0]       pl;
        logic [BYTE_W-1:0] end_b;
        first_byte = bytes_sent;
        first_msg  = sb.produced;
        while (bytes_sent - first_byte < target || sb.produced - first_msg < PHASE_MSGS)
        begin
            kind  = $urandom_range(0, 99);
            id    = ID_W'($urandom);
            len_b = BYTE_W'($urandom_range(0, MAX_PAYLOAD));
            pl    = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0)
                pl[8*$urandom_range(0, 7) +: 8] = cur_start;
            if ($urandom_range(0, 7) == 0)
                id[15:8] = cur_start;
            if (kind < 68)
                send_frame(cur_start, id, len_b, pl, 8'h00, cur_end);
            else if (kind < 76)
                send_frame(cur_start, id, len_b, pl, BYTE_W'($urandom_range(1, 255)),
                           cur_end);
            else if (kind < 84)
            begin
                end_b = cur_end ^ BYTE_W'($urandom_range(1, 255));
                if (cur_start != cur_end && $urandom_range(0, 1) == 0)
                    end_b = cur_start;
                send_frame(cur_start, id, len_b, pl, 8'h00, end_b);
            end
            else if (kind < 90)
                send_frame(cur_start, id, BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255)),
                           pl, 8'h00, cur_end);
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? cur_start
                                                          : BYTE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb            = new();
        cur_start     = START_MARKER_RST;
        cur_end       = END_MARKER_RST;
        bytes_sent    = 0;
        cycle_count   = 0;
        hold_left     = 0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_START_MARKER;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        steady        <= 1'b0;
        pressure_on   <= 1'b0;
        pressure_done <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty frame with the largest id
        send_frame(cur_start, 16'hFFFF, 8'd0, 64'd0, 8'h00, cur_end);
        // Length just above the limit drops the frame at the length byte
        send_frame(cur_start, 16'h0000, 8'd9, 64'd0, 8'h00, cur_end);
        // Start marker as id and payload byte, all-ones payload byte
        send_frame(cur_start, {8'h00, cur_start}, 8'd2, {48'd0, 8'hFF, cur_start},
                   8'h00, cur_end);
        // Wrong end byte equal to the start marker must not open a frame
        send_frame(cur_start, 16'h1234, 8'd0, 64'd0, 8'h00, cur_start);
        send_byte(8'h00);
        send_byte(8'h00);
        send_frame(cur_start, 16'h8001, 8'd1, 64'h80, 8'h00, cur_end);
        random_phase(PHASE_BYTES);
        drain();

        // Lowest start marker, highest end marker, no stalls on either side
        write_reg(REG_START_MARKER, 8'h00);
        write_reg(REG_END_MARKER, 8'hFF);
        steady <= 1'b1;
        random_phase(PHASE_BYTES);
        drain();

        // Highest start marker, lowest end marker, receiver holds off once
        write_reg(REG_START_MARKER, 8'hFF);
        write_reg(REG_END_MARKER, 8'h00);
        steady      <= 1'b0;
        pressure_on <= 1'b1;
        random_phase(PHASE_BYTES);
        drain();

        // Random markers
        write_reg(REG_START_MARKER, CFG_DATA_W'($urandom));
        write_reg(REG_END_MARKER, CFG_DATA_W'($urandom));
        random_phase(PHASE_BYTES);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
